[hw/rtl/psk_symbol_slicer_phase_track_core_defines.svh]
// Assertion macros shared by the slicer RTL.
// Each macro expects clk and rst_n in scope.
`ifndef PSK_SYMBOL_SLICER_PHASE_TRACK_CORE_DEFINES_SVH
`define PSK_SYMBOL_SLICER_PHASE_TRACK_CORE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PSK_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by an expression in the next clock cycle.
`define PSK_ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[hw/rtl/pskslc_pkg.sv]
// ----------------------------------------------------------------------------
// pskslc_pkg
// Widths, constants, constellation and arctangent tables of the slicer.
// ----------------------------------------------------------------------------
package pskslc_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int CHAN_W         = 16;
    localparam int FREQ_W         = 32;
    localparam int PE_W           = 16;
    localparam int GAIN_W         = 16;
    localparam int SPS_W          = 7;
    localparam int XW             = SAMPLE_WIDTH + 8;
    localparam int MW             = XW + 1;
    localparam int PW             = 2 * MW;
    localparam int DW             = 2 * XW + 2;
    localparam int VW             = XW + SAMPLE_WIDTH + 3;
    localparam int CORDIC_STAGES  = 14;
    localparam int ITER_W         = $clog2(CORDIC_STAGES);
    localparam int INV_GAIN       = 19898;
    localparam int CHAN_SHIFT     = 11;
    localparam int GAIN_SHIFT     = 15;

    localparam longint ONE_L  = longint'(1) << (SAMPLE_WIDTH - 2);
    localparam longint HALF_L = (ONE_L * 46341 + 32768) >>> 16;

    localparam logic signed [SAMPLE_WIDTH-1:0] PT_ONE  = SAMPLE_WIDTH'(ONE_L);
    localparam logic signed [SAMPLE_WIDTH-1:0] PT_HALF = SAMPLE_WIDTH'(HALF_L);
    localparam logic signed [SAMPLE_WIDTH-1:0] PT_ZERO = '0;

    localparam logic [1:0] MOD_ASK  = 2'd0;
    localparam logic [1:0] MOD_BPSK = 2'd1;
    localparam logic [1:0] MOD_QPSK = 2'd2;
    localparam logic [1:0] MOD_8PSK = 2'd3;

    localparam logic [1:0] CFG_MODULATION = 2'd0;
    localparam logic [1:0] CFG_TRACK      = 2'd1;
    localparam logic [1:0] CFG_SPS        = 2'd2;
    localparam logic [1:0] CFG_GAIN       = 2'd3;

    typedef struct packed {
        logic [1:0]        modulation;
        logic              phase_track;
        logic [SPS_W-1:0]  sps;
        logic [GAIN_W-1:0] gain;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_i;
        logic signed [SAMPLE_WIDTH-1:0] sample_q;
        logic signed [CHAN_W-1:0]       chan_i;
        logic signed [CHAN_W-1:0]       chan_q;
        logic                           first_symbol;
        logic signed [FREQ_W-1:0]       start_freq;
    } job_t;

    function automatic logic signed [15:0] atan_turn(input logic [ITER_W-1:0] i);
        logic signed [15:0] r;
        case (i)
            4'd0:    r = 16'sd8192;
            4'd1:    r = 16'sd4836;
            4'd2:    r = 16'sd2555;
            4'd3:    r = 16'sd1297;
            4'd4:    r = 16'sd651;
            4'd5:    r = 16'sd326;
            4'd6:    r = 16'sd163;
            4'd7:    r = 16'sd81;
            4'd8:    r = 16'sd41;
            4'd9:    r = 16'sd20;
            4'd10:   r = 16'sd10;
            4'd11:   r = 16'sd5;
            4'd12:   r = 16'sd3;
            4'd13:   r = 16'sd1;
            default: r = 16'sd0;
        endcase
        return r;
    endfunction

    // Angle position on the eighth-turn grid for point p of a mode.
    function automatic logic [2:0] grid_pos(input logic [1:0] m, input logic [2:0] p);
        logic [2:0] k;
        case (m)
            MOD_BPSK: k = {p[0], 2'b00};
            MOD_QPSK: k = {p[1:0], 1'b0};
            default:  k = p;
        endcase
        return k;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] point_x(input logic [1:0] m,
                                                               input logic [2:0] p);
        logic signed [SAMPLE_WIDTH-1:0] r;
        if (m == MOD_ASK)
        begin
            r = p[0] ? PT_ONE : PT_ZERO;
        end
        else
        begin
            case (grid_pos(m, p))
                3'd0:    r = PT_ONE;
                3'd1:    r = PT_HALF;
                3'd2:    r = PT_ZERO;
                3'd3:    r = -PT_HALF;
                3'd4:    r = -PT_ONE;
                3'd5:    r = -PT_HALF;
                3'd6:    r = PT_ZERO;
                default: r = PT_HALF;
            endcase
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] point_y(input logic [1:0] m,
                                                               input logic [2:0] p);
        logic signed [SAMPLE_WIDTH-1:0] r;
        if (m == MOD_ASK)
        begin
            r = PT_ZERO;
        end
        else
        begin
            case (grid_pos(m, p))
                3'd0:    r = PT_ZERO;
                3'd1:    r = PT_HALF;
                3'd2:    r = PT_ONE;
                3'd3:    r = PT_HALF;
                3'd4:    r = PT_ZERO;
                3'd5:    r = -PT_HALF;
                3'd6:    r = -PT_ONE;
                default: r = -PT_HALF;
            endcase
        end
        return r;
    endfunction

endpackage

[hw/rtl/pskslc_if.sv]
// ----------------------------------------------------------------------------
// pskslc_if
// Sample and decision channels of the slicer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pskslc_in_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [pskslc_pkg::SAMPLE_WIDTH-1:0] sample_i;
    logic signed [pskslc_pkg::SAMPLE_WIDTH-1:0] sample_q;
    logic signed [pskslc_pkg::CHAN_W-1:0]       chan_i;
    logic signed [pskslc_pkg::CHAN_W-1:0]       chan_q;
    logic                                       first_symbol;
    logic signed [pskslc_pkg::FREQ_W-1:0]       start_freq;

    modport source (output valid, sample_i, sample_q, chan_i, chan_q, first_symbol,
                    start_freq, input ready);
    modport sink (input valid, sample_i, sample_q, chan_i, chan_q, first_symbol,
                  start_freq, output ready);
endinterface

interface pskslc_out_if;
    logic                                       valid;
    logic                                       ready;
    logic [2:0]                                 symbol_value;
    logic [1:0]                                 bit_count;
    logic signed [pskslc_pkg::SAMPLE_WIDTH-1:0] star_i;
    logic signed [pskslc_pkg::SAMPLE_WIDTH-1:0] star_q;
    logic signed [pskslc_pkg::PE_W-1:0]         phase_error;

    modport source (output valid, symbol_value, bit_count, star_i, star_q, phase_error,
                    input ready);
    modport sink (input valid, symbol_value, bit_count, star_i, star_q, phase_error,
                  output ready);
endinterface

[hw/rtl/pskslc_front.sv]
// ----------------------------------------------------------------------------
// pskslc_front
// Accept sample requests and hold them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module pskslc_front (
    input  logic          clk,
    input  logic          rst_n,
    pskslc_in_if.sink     sym_in,
    pskslc_in_if.source   job
);

    pskslc_pkg::job_t q_mem [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push;
    logic             pop;
    pskslc_pkg::job_t in_job;
    pskslc_pkg::job_t head;

    assign sym_in.ready = (count_reg != 2'd2);
    assign push = sym_in.valid & sym_in.ready;
    assign pop  = job.valid & job.ready;

    always_comb
    begin
        in_job.sample_i     = sym_in.sample_i;
        in_job.sample_q     = sym_in.sample_q;
        in_job.chan_i       = sym_in.chan_i;
        in_job.chan_q       = sym_in.chan_q;
        in_job.first_symbol = sym_in.first_symbol;
        // keep the start frequency only for a burst start
        in_job.start_freq   = sym_in.first_symbol ? sym_in.start_freq : '0;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign head = q_mem[rd_ptr_reg];

    assign job.valid        = (count_reg != 2'd0);
    assign job.sample_i     = head.sample_i;
    assign job.sample_q     = head.sample_q;
    assign job.chan_i       = head.chan_i;
    assign job.chan_q       = head.chan_q;
    assign job.first_symbol = head.first_symbol;
    assign job.start_freq   = head.start_freq;

endmodule

[hw/rtl/pskslc_back.sv]
// ----------------------------------------------------------------------------
// pskslc_back
// Sequenced engine: carrier phase, correction, CORDIC derotation, slicing,
// CORDIC phase error and frequency update.
// ----------------------------------------------------------------------------
`include "psk_symbol_slicer_phase_track_core_defines.svh"

module pskslc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  pskslc_pkg::cfg_t   cfg,
    pskslc_in_if.sink          job,
    pskslc_out_if.source       sym_out
);

    localparam int SW = pskslc_pkg::SAMPLE_WIDTH;
    localparam int XW = pskslc_pkg::XW;
    localparam int MW = pskslc_pkg::MW;
    localparam int PW = pskslc_pkg::PW;
    localparam int DW = pskslc_pkg::DW;
    localparam int VW = pskslc_pkg::VW;
    localparam int FW = pskslc_pkg::FREQ_W;
    localparam int IW = pskslc_pkg::ITER_W;
    localparam logic [IW-1:0] ITER_LAST = IW'(pskslc_pkg::CORDIC_STAGES - 1);

    typedef enum logic [15:0] {
        ST_IDLE  = 16'h0001,
        ST_START = 16'h0002,
        ST_CHAN0 = 16'h0004,
        ST_CHAN1 = 16'h0008,
        ST_CHAN2 = 16'h0010,
        ST_ROTI  = 16'h0020,
        ST_ROT   = 16'h0040,
        ST_GAIN0 = 16'h0080,
        ST_GAIN1 = 16'h0100,
        ST_DIST0 = 16'h0200,
        ST_DIST1 = 16'h0400,
        ST_ERR0  = 16'h0800,
        ST_ERR1  = 16'h1000,
        ST_ERR2  = 16'h2000,
        ST_VEC   = 16'h4000,
        ST_FIN   = 16'h8000
    } state_t;

    state_t                   state_reg, state_next;
    pskslc_pkg::job_t         job_reg;
    logic [FW-1:0]            phase_reg;
    logic [FW-1:0]            freq_reg;
    logic signed [XW-1:0]     x_reg;
    logic signed [XW-1:0]     y_reg;
    logic signed [15:0]       z_reg;
    logic [IW-1:0]            it_reg;
    logic signed [PW-1:0]     pa_reg;
    logic signed [PW-1:0]     pb_reg;
    logic [2:0]               p_reg;
    logic [DW-1:0]            best_reg;
    logic [2:0]               dec_reg;
    logic signed [SW-1:0]     rx_reg;
    logic signed [SW-1:0]     ry_reg;
    logic signed [VW-1:0]     vx_reg;
    logic signed [VW-1:0]     vy_reg;
    logic [15:0]              vz_reg;
    logic                     vzero_reg;
    logic                     out_valid_reg;
    logic [2:0]               sym_reg;
    logic [1:0]               bits_reg;
    logic signed [SW-1:0]     star_i_reg;
    logic signed [SW-1:0]     star_q_reg;
    logic signed [15:0]       pe_reg;

    logic signed [MW-1:0]     ma0, mb0, ma1, mb1;
    logic [2:0]               npts_last;
    logic                     fin_go;
    logic [FW-1:0]            freq_sel;
    logic [FW-1:0]            phase_base;
    logic [FW-1:0]            phase_step;
    logic [FW-1:0]            neg_phase;
    logic [15:0]              a16;
    logic [15:0]              a_q;
    logic [1:0]               quad;
    logic signed [PW-1:0]     chan_sum;
    logic signed [PW-1:0]     chan_dif;
    logic signed [PW-1:0]     gain_x;
    logic signed [PW-1:0]     gain_y;
    logic signed [XW-1:0]     rdx, rdy;
    logic signed [VW-1:0]     vdx, vdy;
    logic signed [SW-1:0]     cand_x, cand_y;
    logic signed [MW-1:0]     ex, ey;
    logic [DW-1:0]            dist_sum;
    logic [2:0]               gray;
    logic                     take;
    logic signed [VW-1:0]     err_y;
    logic signed [15:0]       pe_val;
    logic signed [FW:0]       freq_adj;

    function automatic logic signed [SW-1:0] sat_sw(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = XW'((longint'(1) << (SW - 1)) - 1);
        lo = -hi - XW'(1);
        if (v > hi)
        begin
            return SW'(hi);
        end
        else if (v < lo)
        begin
            return SW'(lo);
        end
        return SW'(v);
    endfunction

    assign job.ready = (state_reg == ST_IDLE);
    assign fin_go    = !out_valid_reg || sym_out.ready;

    always_comb
    begin
        case (cfg.modulation)
            pskslc_pkg::MOD_QPSK: npts_last = 3'd3;
            pskslc_pkg::MOD_8PSK: npts_last = 3'd7;
            default:              npts_last = 3'd1;
        endcase
    end

    // Carrier phase step: reload on burst start, advance by freq * sps when tracking is on.
    assign freq_sel   = job_reg.first_symbol ? job_reg.start_freq : freq_reg;
    assign phase_base = job_reg.first_symbol ? '0 : phase_reg;
    assign phase_step = FW'(freq_sel * cfg.sps);

    // Derotation angle: negate phase, round to 16 bits, split off quadrant.
    assign neg_phase = (~phase_reg + FW'(1)) + FW'(32'h8000);
    assign a16       = neg_phase[FW-1:FW-16];
    assign a_q       = a16 + 16'h2000;
    assign quad      = a_q[15:14];

    assign chan_dif = pa_reg - pb_reg + PW'(1 << (pskslc_pkg::CHAN_SHIFT - 1));
    assign chan_sum = pa_reg + pb_reg + PW'(1 << (pskslc_pkg::CHAN_SHIFT - 1));
    assign gain_x   = pa_reg + PW'(1 << (pskslc_pkg::GAIN_SHIFT - 1));
    assign gain_y   = pb_reg + PW'(1 << (pskslc_pkg::GAIN_SHIFT - 1));

    assign rdx = y_reg >>> it_reg;
    assign rdy = x_reg >>> it_reg;
    assign vdx = vy_reg >>> it_reg;
    assign vdy = vx_reg >>> it_reg;

    assign cand_x   = pskslc_pkg::point_x(cfg.modulation, p_reg);
    assign cand_y   = pskslc_pkg::point_y(cfg.modulation, p_reg);
    assign ex       = MW'(x_reg) - MW'(cand_x);
    assign ey       = MW'(y_reg) - MW'(cand_y);
    assign dist_sum = pa_reg[DW-1:0] + pb_reg[DW-1:0];
    assign gray     = p_reg ^ {1'b0, p_reg[2:1]};
    assign take     = (p_reg == 3'd0) || (dist_sum < best_reg) ||
                      ((dist_sum == best_reg) && (gray < dec_reg));

    assign err_y    = VW'(pa_reg - pb_reg);
    assign pe_val   = vzero_reg ? 16'sd0 : $signed(vz_reg);
    assign freq_adj = (FW + 1)'(pe_val * $signed({1'b0, cfg.gain}));

    // Operand select for the two shared multipliers.
    always_comb
    begin
        ma0 = '0;
        mb0 = '0;
        ma1 = '0;
        mb1 = '0;
        case (state_reg)
            ST_CHAN0:
            begin
                ma0 = MW'(job_reg.sample_i);
                mb0 = MW'(job_reg.chan_i);
                ma1 = MW'(job_reg.sample_q);
                mb1 = MW'(job_reg.chan_q);
            end
            ST_CHAN1:
            begin
                ma0 = MW'(job_reg.sample_i);
                mb0 = MW'(job_reg.chan_q);
                ma1 = MW'(job_reg.sample_q);
                mb1 = MW'(job_reg.chan_i);
            end
            ST_GAIN0:
            begin
                ma0 = MW'(x_reg);
                mb0 = MW'(pskslc_pkg::INV_GAIN);
                ma1 = MW'(y_reg);
                mb1 = MW'(pskslc_pkg::INV_GAIN);
            end
            ST_DIST0:
            begin
                ma0 = ex;
                mb0 = ex;
                ma1 = ey;
                mb1 = ey;
            end
            ST_ERR0:
            begin
                ma0 = MW'(x_reg);
                mb0 = MW'(rx_reg);
                ma1 = MW'(y_reg);
                mb1 = MW'(ry_reg);
            end
            ST_ERR1:
            begin
                ma0 = MW'(y_reg);
                mb0 = MW'(rx_reg);
                ma1 = MW'(x_reg);
                mb1 = MW'(ry_reg);
            end
            default:
            begin
                ma0 = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        pa_reg <= ma0 * mb0;
        pb_reg <= ma1 * mb1;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (job.valid) state_next = ST_START;
            ST_START: state_next = ST_CHAN0;
            ST_CHAN0: state_next = ST_CHAN1;
            ST_CHAN1: state_next = ST_CHAN2;
            ST_CHAN2: state_next = ST_ROTI;
            ST_ROTI:  state_next = ST_ROT;
            ST_ROT:   if (it_reg == ITER_LAST) state_next = ST_GAIN0;
            ST_GAIN0: state_next = ST_GAIN1;
            ST_GAIN1: state_next = ST_DIST0;
            ST_DIST0: state_next = ST_DIST1;
            ST_DIST1: state_next = (p_reg == npts_last) ? ST_ERR0 : ST_DIST0;
            ST_ERR0:  state_next = ST_ERR1;
            ST_ERR1:  state_next = ST_ERR2;
            ST_ERR2:  state_next = ST_VEC;
            ST_VEC:   if (it_reg == ITER_LAST) state_next = ST_FIN;
            ST_FIN:   if (fin_go) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                job_reg.sample_i     <= job.sample_i;
                job_reg.sample_q     <= job.sample_q;
                job_reg.chan_i       <= job.chan_i;
                job_reg.chan_q       <= job.chan_q;
                job_reg.first_symbol <= job.first_symbol;
                job_reg.start_freq   <= job.start_freq;
            end
            ST_CHAN1:
            begin
                x_reg <= XW'(chan_dif >>> pskslc_pkg::CHAN_SHIFT);
            end
            ST_CHAN2:
            begin
                y_reg <= XW'(chan_sum >>> pskslc_pkg::CHAN_SHIFT);
            end
            ST_ROTI:
            begin
                // apply the nearest quarter turn exactly
                case (quad)
                    2'd1:
                    begin
                        x_reg <= -y_reg;
                        y_reg <= x_reg;
                    end
                    2'd2:
                    begin
                        x_reg <= -x_reg;
                        y_reg <= -y_reg;
                    end
                    2'd3:
                    begin
                        x_reg <= y_reg;
                        y_reg <= -x_reg;
                    end
                    default:
                    begin
                        x_reg <= x_reg;
                    end
                endcase
                z_reg  <= $signed(a16 - {quad, 14'b0});
                it_reg <= '0;
            end
            ST_ROT:
            begin
                if (!z_reg[15])
                begin
                    x_reg <= x_reg - rdx;
                    y_reg <= y_reg + rdy;
                    z_reg <= z_reg - pskslc_pkg::atan_turn(it_reg);
                end
                else
                begin
                    x_reg <= x_reg + rdx;
                    y_reg <= y_reg - rdy;
                    z_reg <= z_reg + pskslc_pkg::atan_turn(it_reg);
                end
                it_reg <= it_reg + IW'(1);
            end
            ST_GAIN1:
            begin
                x_reg <= XW'(gain_x >>> pskslc_pkg::GAIN_SHIFT);
                y_reg <= XW'(gain_y >>> pskslc_pkg::GAIN_SHIFT);
                p_reg <= 3'd0;
            end
            ST_DIST1:
            begin
                if (take)
                begin
                    best_reg <= dist_sum;
                    dec_reg  <= gray;
                    rx_reg   <= cand_x;
                    ry_reg   <= cand_y;
                end
                p_reg <= p_reg + 3'd1;
            end
            ST_ERR1:
            begin
                vx_reg <= VW'(pa_reg + pb_reg);
            end
            ST_ERR2:
            begin
                // half-turn pre-rotation for a negative real part
                vzero_reg <= ((rx_reg == '0) && (ry_reg == '0)) ||
                             ((vx_reg == '0) && (err_y == '0));
                if (vx_reg < 0)
                begin
                    vx_reg <= -vx_reg;
                    vy_reg <= -err_y;
                    vz_reg <= 16'h8000;
                end
                else
                begin
                    vy_reg <= err_y;
                    vz_reg <= 16'h0000;
                end
                it_reg <= '0;
            end
            ST_VEC:
            begin
                if (vy_reg > 0)
                begin
                    vx_reg <= vx_reg + vdx;
                    vy_reg <= vy_reg - vdy;
                    vz_reg <= vz_reg + pskslc_pkg::atan_turn(it_reg);
                end
                else
                begin
                    vx_reg <= vx_reg - vdx;
                    vy_reg <= vy_reg + vdy;
                    vz_reg <= vz_reg - pskslc_pkg::atan_turn(it_reg);
                end
                it_reg <= it_reg + IW'(1);
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    sym_reg    <= dec_reg;
                    bits_reg   <= (cfg.modulation == pskslc_pkg::MOD_ASK) ? 2'd1
                                                                        : cfg.modulation;
                    star_i_reg <= sat_sw(x_reg);
                    star_q_reg <= sat_sw(y_reg);
                    pe_reg     <= pe_val;
                end
            end
            default:
            begin
                it_reg <= it_reg;
            end
        endcase
    end

    // Control state, output valid, carrier phase and frequency.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            freq_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_START)
            begin
                freq_reg  <= freq_sel;
                phase_reg <= cfg.phase_track ? phase_base + phase_step : phase_base;
            end
            if ((state_reg == ST_FIN) && fin_go)
            begin
                out_valid_reg <= 1'b1;
                if (cfg.phase_track)
                begin
                    freq_reg <= freq_reg + freq_adj[FW-1:0];
                end
            end
            else if (sym_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sym_out.valid        = out_valid_reg;
    assign sym_out.symbol_value = sym_reg;
    assign sym_out.bit_count    = bits_reg;
    assign sym_out.star_i       = star_i_reg;
    assign sym_out.star_q       = star_q_reg;
    assign sym_out.phase_error  = pe_reg;

    `PSK_ASSERT_CLK(a_iter_range, ((state_reg == ST_ROT) || (state_reg == ST_VEC)) |-> (it_reg <= ITER_LAST), "CORDIC iteration past last stage")
    `PSK_ASSERT_CLK(a_point_range, ((state_reg == ST_DIST0) || (state_reg == ST_DIST1)) |-> (p_reg <= npts_last), "point index past constellation")
    `PSK_ASSERT_NEXT(a_fin_idle, (state_reg == ST_FIN) && fin_go, (state_reg == ST_IDLE) && out_valid_reg, "finished symbol not presented")

endmodule

[hw/rtl/psk_symbol_slicer_phase_track_core.sv]
// ----------------------------------------------------------------------------
// psk_symbol_slicer_phase_track_core
// ASK / BPSK / QPSK / 8PSK slicer with decision-directed carrier tracking.
// ----------------------------------------------------------------------------
// One symbol request on sym_in gives one decision on sym_out. A request is
// queued (two entries) and then worked by a single sequenced engine, one
// symbol at a time, which compares the sample with each of the M
// constellation points in turn. Acceptance registers the request in the
// queue before the engine sees it, and a stalled sym_out holds the engine
// in its last step. The run of a symbol is set by the two 14-step CORDIC
// loops (derotation and phase error) and by the distance evaluation per
// point (DIST0, DIST1); the next symbol starts only after the frequency
// update of the current one. The output register lets the engine work the
// next symbol up to its last step while the previous decision is still
// waiting on sym_out.
// Configuration is written through cfg_we / cfg_index / cfg_wdata (index 0
// modulation, 1 phase_track, 2 samples_per_symbol, 3 track_gain); the user
// must write it only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module psk_symbol_slicer_phase_track_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_wdata,
    pskslc_in_if.sink     sym_in,
    pskslc_out_if.source  sym_out
);

    logic [1:0]                       modulation_reg;
    logic                             phase_track_reg;
    logic [pskslc_pkg::SPS_W-1:0]     sps_reg;
    logic [pskslc_pkg::GAIN_W-1:0]    gain_reg;
    pskslc_pkg::cfg_t                 cfg;

    // Hold the configuration registers; write on enable, no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulation_reg  <= pskslc_pkg::MOD_QPSK;
            phase_track_reg <= 1'b0;
            sps_reg         <= pskslc_pkg::SPS_W'(4);
            gain_reg        <= pskslc_pkg::GAIN_W'(82);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pskslc_pkg::CFG_MODULATION: modulation_reg  <= cfg_wdata[1:0];
                pskslc_pkg::CFG_TRACK:      phase_track_reg <= cfg_wdata[0];
                pskslc_pkg::CFG_SPS:        sps_reg <= cfg_wdata[pskslc_pkg::SPS_W-1:0];
                pskslc_pkg::CFG_GAIN:       gain_reg <= cfg_wdata;
                default:                    gain_reg <= gain_reg;
            endcase
        end
    end

    assign cfg.modulation  = modulation_reg;
    assign cfg.phase_track = phase_track_reg;
    assign cfg.sps         = sps_reg;
    assign cfg.gain        = gain_reg;

    // Queue between request acceptance and the engine.
    pskslc_in_if job_ch ();

    pskslc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .sym_in (sym_in),
        .job    (job_ch.source)
    );

    // Engine: phase advance, correction, derotation, slicing, tracking.
    pskslc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .job     (job_ch.sink),
        .sym_out (sym_out)
    );

endmodule
